### rtl/utf8cp_pkg.sv
package utf8cp_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CP_W           = 21;
    localparam int PAYLOAD_W      = 7;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET = 16'hFFFF;
    localparam logic                  LIMIT_RESET    = 1'b1;

    // register indexes on the config channel
    localparam logic CFG_OUT_CAPACITY = 1'b0;
    localparam logic CFG_LIMIT_ENABLE = 1'b1;

    // byte masks and class bounds
    localparam logic [7:0] MASK_LEAD4_TAG = 8'hF8;
    localparam logic [7:0] TAG_LEAD4      = 8'hF0;
    localparam logic [7:0] MASK_CONT_TAG  = 8'hC0;
    localparam logic [7:0] TAG_CONT       = 8'h80;
    localparam logic [7:0] MASK_LEAD2     = 8'h1F;
    localparam logic [7:0] MASK_LEAD3     = 8'h0F;
    localparam logic [7:0] MASK_LEAD4     = 8'h07;
    localparam logic [7:0] MASK_ASCII     = 8'h7F;
    localparam logic [7:0] MASK_CONT      = 8'h3F;
    localparam logic [7:0] LIM_LEAD2      = 8'hC0;
    localparam logic [7:0] LIM_LEAD3      = 8'hE0;
    localparam logic [7:0] LIM_LEAD4      = 8'hF0;

    localparam logic [7:0] BASE_LOW  = 8'h7F;
    localparam logic [7:0] BASE_HIGH = 8'hE0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_INVALID = 2'd2,
        ST_NO_ROOM = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_ASCII,
        K_CONT,
        K_LEAD2,
        K_LEAD3,
        K_LEAD4,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [PAYLOAD_W-1:0] payload;
        logic                 eos;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } t_map;

    localparam int N_LOW  = 42;
    localparam int N_HIGH = 32;

    localparam logic [15:0] LOW_GLYPHS [N_LOW] = '{
        16'h2302,
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF
    };

    localparam logic [15:0] HIGH_GLYPHS [N_HIGH] = '{
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    // code point to CP437 glyph; each compare is independent
    function automatic t_map map_cp(input logic [CP_W-1:0] cp);
        t_map r;
        r.hit  = 1'b0;
        r.code = 8'h00;
        if (cp[CP_W-1:7] == '0) begin
            r.hit  = 1'b1;
            r.code = {1'b0, cp[6:0]};
        end
        for (int i = 0; i < N_LOW; i++) begin
            if (cp == {5'b0, LOW_GLYPHS[i]}) begin
                r.hit  = 1'b1;
                r.code = BASE_LOW + 8'(i);
            end
        end
        for (int i = 0; i < N_HIGH; i++) begin
            if (cp == {5'b0, HIGH_GLYPHS[i]}) begin
                r.hit  = 1'b1;
                r.code = BASE_HIGH + 8'(i);
            end
        end
        return r;
    endfunction

endpackage

### rtl/utf8cp_front.sv
module utf8cp_front (
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    input  logic                 i_eos,
    input  utf8cp_pkg::t_q_stat  i_q_stat,
    output logic                 o_ready,
    output logic                 o_push,
    output utf8cp_pkg::t_item    o_item
);
    import utf8cp_pkg::*;

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    // byte class and masked payload bits
    always_comb begin
        o_item.eos = i_eos;
        if (i_byte < TAG_CONT) begin
            o_item.kind    = K_ASCII;
            o_item.payload = PAYLOAD_W'(i_byte & MASK_ASCII);
        end else if (i_byte < LIM_LEAD2) begin
            o_item.kind    = K_CONT;
            o_item.payload = PAYLOAD_W'(i_byte & MASK_CONT);
        end else if (i_byte < LIM_LEAD3) begin
            o_item.kind    = K_LEAD2;
            o_item.payload = PAYLOAD_W'(i_byte & MASK_LEAD2);
        end else if (i_byte < LIM_LEAD4) begin
            o_item.kind    = K_LEAD3;
            o_item.payload = PAYLOAD_W'(i_byte & MASK_LEAD3);
        end else if ((i_byte & MASK_LEAD4_TAG) == TAG_LEAD4) begin
            o_item.kind    = K_LEAD4;
            o_item.payload = PAYLOAD_W'(i_byte & MASK_LEAD4);
        end else begin
            o_item.kind    = K_BAD;
            o_item.payload = '0;
        end
    end

endmodule

### rtl/utf8cp_queue.sv
module utf8cp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  utf8cp_pkg::t_item   i_item,
    input  logic                i_pop,
    output utf8cp_pkg::t_item   o_item,
    output utf8cp_pkg::t_q_stat o_stat
);
    import utf8cp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]     r_count, n_count;

    assign o_stat.full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/utf8cp_back.sv
module utf8cp_back #(
    parameter int COUNT_BITS = utf8cp_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  utf8cp_pkg::t_q_stat i_q_stat,
    input  utf8cp_pkg::t_item   i_item,
    output logic                o_pop,
    input  logic [15:0]         i_capacity,
    input  logic                i_limit_en,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_char_valid,
    output logic [7:0]          o_code,
    output utf8cp_pkg::t_status o_status,
    output logic [15:0]         o_count,
    output logic                o_done
);
    import utf8cp_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [CP_W-1:0]       r_cp, n_cp;
    logic [1:0]            r_rem, n_rem;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    t_status               r_err, n_err;

    logic                  r_out_valid;
    logic                  r_char_valid, n_char_valid;
    logic [7:0]            r_code, n_code;
    t_status               r_status;
    logic [15:0]           r_count, n_count;
    logic                  r_done;

    logic [CP_W-1:0]       asm_cp;
    t_map                  map;
    logic                  full_now;
    logic [CMP_W-1:0]      cnt_ext;

    assign o_pop = !i_q_stat.empty && (!r_out_valid || i_ready);

    // code point as it stands once this byte is folded in
    assign asm_cp = (r_rem == 2'd0) ? CP_W'(i_item.payload)
                                    : {r_cp[CP_W-7:0], i_item.payload[5:0]};
    assign map = map_cp(asm_cp);
    assign full_now = i_limit_en && (CMP_W'(r_cnt) >= CMP_W'(i_capacity));

    always_comb begin
        logic    complete;
        t_status err;
        n_cp         = r_cp;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_err        = r_err;
        n_char_valid = 1'b0;
        n_code       = 8'h00;
        complete     = 1'b0;
        err          = ST_OK;
        cnt_ext      = '0;
        if (r_err == ST_OK) begin
            if (r_rem == 2'd0) begin
                if (full_now) begin
                    err = ST_NO_ROOM;
                end else begin
                    case (i_item.kind)
                        K_ASCII: begin
                            n_cp     = asm_cp;
                            complete = 1'b1;
                        end
                        K_LEAD2: begin
                            n_cp  = asm_cp;
                            n_rem = 2'd1;
                        end
                        K_LEAD3: begin
                            n_cp  = asm_cp;
                            n_rem = 2'd2;
                        end
                        K_LEAD4: begin
                            n_cp  = asm_cp;
                            n_rem = 2'd3;
                        end
                        default: err = ST_INVALID;
                    endcase
                end
            end else if (i_item.kind != K_CONT) begin
                err = ST_INVALID;
            end else begin
                n_cp  = asm_cp;
                n_rem = r_rem - 2'd1;
                complete = (r_rem == 2'd1);
            end
            // string ends while continuation bytes are still owed
            if (err == ST_OK && !complete && i_item.eos && n_rem != 2'd0) begin
                err = ST_INVALID;
            end
            if (err == ST_OK && complete) begin
                if (map.hit) begin
                    n_char_valid = 1'b1;
                    n_code       = map.code;
                    if (r_cnt != '1) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    err = ST_UNKNOWN;
                end
            end
            if (err != ST_OK) begin
                n_err = err;
                if (err != ST_NO_ROOM) begin
                    n_cnt = '0;
                end
            end
        end
        cnt_ext = CMP_W'(n_cnt);
        if (n_err == ST_UNKNOWN || n_err == ST_INVALID) begin
            n_count = '0;
        end else if (cnt_ext > CMP_W'(16'hFFFF)) begin
            n_count = 16'hFFFF;
        end else begin
            n_count = cnt_ext[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp        <= '0;
            r_rem       <= '0;
            r_cnt       <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_item.eos) begin
                    r_cp  <= '0;
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_err <= ST_OK;
                end else begin
                    r_cp  <= n_cp;
                    r_rem <= n_rem;
                    r_cnt <= n_cnt;
                    r_err <= n_err;
                end
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_char_valid <= n_char_valid;
            r_code       <= n_code;
            r_status     <= n_err;
            r_count      <= n_count;
            r_done       <= i_item.eos;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_char_valid = r_char_valid;
    assign o_code       = r_code;
    assign o_status     = r_status;
    assign o_count      = r_count;
    assign o_done       = r_done;

endmodule

### rtl/utf8_to_cp437_transcoder.sv
// UTF-8 to code page 437 transcoder.
// Slave stream: one raw UTF-8 byte per transaction in s_axis_tdata, with
// s_axis_tlast marking the last byte of a string.
// Master stream: exactly one result transaction per input byte.
//   tdata = {char_count[15:0], cp437_code[7:0]}, tuser = {status, char_valid},
//   tlast echoes the input tlast. After a tlast byte the string state clears.
// Config channel: cfg_valid/cfg_ready with index 0 = out_capacity,
//   index 1 = limit_enable. cfg_ready is always high; write only while idle.
// Path: the classifier writes each accepted byte into the two-entry queue,
//   and decode/map moves it from the queue into the output register once
//   that register is free. Throughput: one byte per cycle while
//   m_axis_tready stays high, set by the single decode stage that folds one
//   byte into the code point and maps it.
// Stall: when m_axis_tready is low the output register holds, the queue
//   fills, and s_axis_tready drops once both queue entries are taken.
// Reset (synchronous, active low): queue empties, string state clears,
//   out_capacity returns to 65535 and limit_enable to 1. No clearing pass.
module utf8_to_cp437_transcoder #(
    parameter int COUNT_BITS = utf8cp_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] utf8_byte
    input  logic        s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] cp437_code, [23:8] char_count
    output logic [2:0]  m_axis_tuser,   // [0] char_valid, [2:1] status
    output logic        m_axis_tlast,   // string_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import utf8cp_pkg::*;

    logic [15:0] r_capacity;
    logic        r_limit_en;

    t_item   fr_item, q_item;
    t_q_stat q_stat;
    logic    push, pop;

    logic        char_valid;
    logic [7:0]  code;
    t_status     status;
    logic [15:0] count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
            r_limit_en <= LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_OUT_CAPACITY: r_capacity <= cfg_data;
                CFG_LIMIT_ENABLE: r_limit_en <= cfg_data[0];
                default: ;
            endcase
        end
    end

    utf8cp_front u_front (
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_eos    (s_axis_tlast),
        .i_q_stat (q_stat),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_item   (fr_item)
    );

    utf8cp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (fr_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    utf8cp_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_item       (q_item),
        .o_pop        (pop),
        .i_capacity   (r_capacity),
        .i_limit_en   (r_limit_en),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_char_valid (char_valid),
        .o_code       (code),
        .o_status     (status),
        .o_count      (count),
        .o_done       (m_axis_tlast)
    );

    assign m_axis_tdata = {count, code};
    assign m_axis_tuser = {status, char_valid};

    // queue can never be both full and empty
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // a mapped character only comes with a clean status
    a_char_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && char_valid) |-> (status == ST_OK))
        else $error("char_valid with error status");

    // decode and mapping errors zero the count
    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (status == ST_UNKNOWN || status == ST_INVALID)) |-> (count == '0))
        else $error("nonzero count after decode error");

    // a popped item always reaches the output register next cycle
    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> m_axis_tvalid)
        else $error("popped item did not reach output");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import utf8cp_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_CYCLES     = 200;   // long receiver hold-off
    localparam int DRAIN_CYCLES    = 8;     // two-stage pipe plus margin
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 75;

    // One master-side transaction, split into its fields.
    typedef struct packed {
        logic        char_valid;
        logic [7:0]  cp437_code;
        t_status     status;
        logic [15:0] char_count;
        logic        string_done;
    } t_cp437_out;

    // Directed row: input byte, tlast, and optionally a hand-written result.
    typedef struct packed {
        logic       data;
        logic [7:0] byte_val;
        logic       last;
        t_cp437_out want;
    } t_byte_row;

    localparam t_cp437_out NO_RES = '{1'b0, 8'h00, ST_OK, 16'd0, 1'b0};

    // CP437 0x7F..0xA8
    localparam logic [15:0] LATIN_GLYPHS [42] = '{
        16'h2302,
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF
    };

    // CP437 0xE0..0xFF
    localparam logic [15:0] GREEK_MATH_GLYPHS [32] = '{
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    // Directed bytes. The first field says whether the result is hand-written;
    // rows without one are checked against the predictor.
    localparam int N_DIRECTED = 27;
    localparam t_byte_row BYTE_TABLE [N_DIRECTED] = '{
        // ASCII extremes, two characters in one string
        '{1'b1, 8'h00, 1'b0, '{1'b1, 8'h00, ST_OK, 16'd1, 1'b0}},
        '{1'b1, 8'h7F, 1'b1, '{1'b1, 8'h7F, ST_OK, 16'd2, 1'b1}},
        // stray continuation as lead byte
        '{1'b1, 8'h80, 1'b1, '{1'b0, 8'h00, ST_INVALID, 16'd0, 1'b1}},
        // 0xFF lead, then a byte ignored under the latched error
        '{1'b1, 8'hFF, 1'b0, '{1'b0, 8'h00, ST_INVALID, 16'd0, 1'b0}},
        '{1'b1, 8'h41, 1'b1, '{1'b0, 8'h00, ST_INVALID, 16'd0, 1'b1}},
        // mapped glyphs: U+00C7, U+2302, U+03B1, U+00A0
        '{1'b1, 8'hC3, 1'b0, '{1'b0, 8'h00, ST_OK, 16'd0, 1'b0}},
        '{1'b0, 8'h87, 1'b0, NO_RES},
        '{1'b0, 8'hE2, 1'b0, NO_RES},
        '{1'b0, 8'h8C, 1'b0, NO_RES},
        '{1'b0, 8'h82, 1'b0, NO_RES},
        '{1'b0, 8'hCE, 1'b0, NO_RES},
        '{1'b0, 8'hB1, 1'b0, NO_RES},
        '{1'b0, 8'hC2, 1'b0, NO_RES},
        '{1'b0, 8'hA0, 1'b1, NO_RES},
        // box drawing U+2500 has no glyph here
        '{1'b0, 8'hE2, 1'b0, NO_RES},
        '{1'b0, 8'h94, 1'b0, NO_RES},
        '{1'b1, 8'h80, 1'b1, '{1'b0, 8'h00, ST_UNKNOWN, 16'd0, 1'b1}},
        // largest four-byte code point, 0x1FFFFF
        '{1'b0, 8'hF7, 1'b0, NO_RES},
        '{1'b0, 8'hBF, 1'b0, NO_RES},
        '{1'b0, 8'hBF, 1'b0, NO_RES},
        '{1'b1, 8'hBF, 1'b1, '{1'b0, 8'h00, ST_UNKNOWN, 16'd0, 1'b1}},
        // bad continuation
        '{1'b0, 8'hC3, 1'b0, NO_RES},
        '{1'b1, 8'h41, 1'b1, '{1'b0, 8'h00, ST_INVALID, 16'd0, 1'b1}},
        // string ends mid-sequence
        '{1'b0, 8'hE2, 1'b0, NO_RES},
        '{1'b1, 8'h82, 1'b1, '{1'b0, 8'h00, ST_INVALID, 16'd0, 1'b1}},
        // overlong NUL is accepted
        '{1'b0, 8'hC0, 1'b0, NO_RES},
        '{1'b0, 8'h80, 1'b1, NO_RES}
    };

    // DUT ports; every input is known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic        cfg_index     = CFG_OUT_CAPACITY;
    logic [15:0] cfg_data      = 16'h0000;

    // Predictor copy of config and per-string state
    logic [15:0] out_cap   = 16'hFFFF;
    logic        limit_on  = 1'b1;
    logic [20:0] cp_acc    = '0;
    logic [1:0]  cont_left = '0;
    logic [15:0] n_chars   = '0;
    t_status     err_latch = ST_OK;

    // Results still owed by the DUT, oldest first
    t_cp437_out expected_out [$];
    logic [7:0] string_bytes [$];

    t_cp437_out seen_out;
    t_cp437_out want_out;
    int         n_fail   = 0;
    int         n_sent   = 0;
    int         n_cycles = 0;
    bit         quiet    = 1'b0;  // no idling on either side
    bit         hold_req = 1'b0;  // receiver long hold-off request
    bit         offering = 1'b0;  // sender currently driving tvalid high

    utf8_to_cp437_transcoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Code point to CP437 byte; returns 0 when there is no glyph.
    function automatic logic lookup_glyph(input logic [20:0] cp, output logic [7:0] code);
        code = 8'h00;
        if (cp < 21'h80) begin
            code = {1'b0, cp[6:0]};
            return 1'b1;
        end
        for (int i = 0; i < 42; i++) begin
            if (cp == {5'b0, LATIN_GLYPHS[i]}) begin
                code = 8'h7F + 8'(i);
                return 1'b1;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (cp == {5'b0, GREEK_MATH_GLYPHS[i]}) begin
                code = 8'hE0 + 8'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Fold one byte into the string state and form its result.
    function automatic t_cp437_out transcode_byte(input logic [7:0] b, input logic eol);
        t_cp437_out r;
        t_status    err;
        logic       cp_done;
        logic [7:0] code;
        r           = NO_RES;
        err         = ST_OK;
        cp_done     = 1'b0;
        code        = 8'h00;
        if (err_latch == ST_OK) begin
            if (cont_left == 2'd0) begin
                // capacity is checked before each new character starts
                if (limit_on && n_chars >= out_cap) begin
                    err = ST_NO_ROOM;
                end else if (b < 8'h80) begin
                    cp_acc  = {13'b0, b};
                    cp_done = 1'b1;
                end else if (b < 8'hC0) begin
                    err = ST_INVALID;
                end else if (b < 8'hE0) begin
                    cp_acc    = {16'b0, b[4:0]};
                    cont_left = 2'd1;
                end else if (b < 8'hF0) begin
                    cp_acc    = {17'b0, b[3:0]};
                    cont_left = 2'd2;
                end else if (b < 8'hF8) begin
                    cp_acc    = {18'b0, b[2:0]};
                    cont_left = 2'd3;
                end else begin
                    err = ST_INVALID;
                end
            end else if (b[7:6] != 2'b10) begin
                err = ST_INVALID;
            end else begin
                cp_acc    = {cp_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                cp_done   = (cont_left == 2'd0);
            end
            // string ends while continuation bytes are still owed
            if (err == ST_OK && !cp_done && eol && cont_left != 2'd0)
                err = ST_INVALID;
            if (err == ST_OK && cp_done) begin
                if (lookup_glyph(cp_acc, code)) begin
                    r.char_valid = 1'b1;
                    r.cp437_code = code;
                    if (n_chars != 16'hFFFF)
                        n_chars = n_chars + 16'd1;
                end else begin
                    err = ST_UNKNOWN;
                end
            end
            if (err != ST_OK) begin
                err_latch = err;
                if (err != ST_NO_ROOM)
                    n_chars = '0;
            end
        end
        r.status      = err_latch;
        r.char_count  = (err_latch == ST_UNKNOWN || err_latch == ST_INVALID) ? 16'd0 : n_chars;
        r.string_done = eol;
        if (eol) begin
            cp_acc    = '0;
            cont_left = '0;
            n_chars   = '0;
            err_latch = ST_OK;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic void add_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            string_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            string_bytes.push_back({3'b110, cp[10:6]});
            string_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            string_bytes.push_back({4'b1110, cp[15:12]});
            string_bytes.push_back({2'b10, cp[11:6]});
            string_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            string_bytes.push_back({5'b11110, cp[20:18]});
            string_bytes.push_back({2'b10, cp[17:12]});
            string_bytes.push_back({2'b10, cp[11:6]});
            string_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    // Drop tvalid once; never twice in the same step.
    task automatic stop_offer();
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Offer one byte, wait for the transaction, then record what it owes.
    task automatic send_item(input logic [7:0] b, input logic eol, input logic typed,
                             input t_cp437_out want);
        t_cp437_out predicted;
        while (!quiet && $urandom_range(0, 99) < 20) begin
            stop_offer();
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eol;
        offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = transcode_byte(b, eol);
        expected_out.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    // Sender pauses until every owed result has come back.
    task automatic wait_drained();
        stop_offer();
        while (expected_out.size() != 0)
            @(posedge i_clk);
    endtask

    // Both registers in one go, so cfg_valid stays high between them.
    task automatic write_config(input logic [15:0] cap, input logic lim);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_OUT_CAPACITY;
        cfg_data  <= cap;
        do @(posedge i_clk); while (!cfg_ready);
        out_cap = cap;
        cfg_index <= CFG_LIMIT_ENABLE;
        cfg_data  <= {15'b0, lim};
        do @(posedge i_clk); while (!cfg_ready);
        limit_on = lim;
        cfg_valid <= 1'b0;
    endtask

    // One random string. Most strings are clean UTF-8; the rest mix in
    // broken pieces: bad leads, bad continuations, cut sequences, raw bytes.
    task automatic send_random_string();
        int          len;
        int          pick;
        int          top;
        logic [20:0] cp;
        logic [7:0]  nc;
        string_bytes.delete();
        len = $urandom_range(1, 10);
        top = ($urandom_range(0, 9) < 3) ? 99 : 75;
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, top);
            if (pick < 30) begin
                add_code_point(21'($urandom_range(0, 127)));
            end else if (pick < 55) begin
                if ($urandom_range(0, 1))
                    add_code_point({5'b0, LATIN_GLYPHS[$urandom_range(0, 41)]});
                else
                    add_code_point({5'b0, GREEK_MATH_GLYPHS[$urandom_range(0, 31)]});
            end else if (pick < 63) begin
                add_code_point(21'($urandom_range(21'h2500, 21'h257F)));
            end else if (pick < 71) begin
                add_code_point(21'($urandom_range(0, 21'h1FFFFF)));
            end else if (pick < 76) begin
                // overlong two-byte form of an ASCII char
                cp = 21'($urandom_range(0, 127));
                string_bytes.push_back({7'b1100000, cp[6]});
                string_bytes.push_back({2'b10, cp[5:0]});
            end else if (pick < 82) begin
                add_code_point(21'($urandom_range(21'h80, 21'h1FFFFF)));
                void'(string_bytes.pop_back());
            end else if (pick < 88) begin
                if ($urandom_range(0, 1))
                    string_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                else
                    string_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            end else if (pick < 94) begin
                nc = 8'($urandom);
                if (nc[7:6] == 2'b10)
                    nc[7] = 1'b0;
                string_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
                string_bytes.push_back(nc);
            end else begin
                string_bytes.push_back(8'($urandom));
            end
        end
        for (int k = 0; k < string_bytes.size(); k++)
            send_item(string_bytes[k], k == string_bytes.size() - 1, 1'b0, NO_RES);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random tready, or a long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_out.char_valid  = m_axis_tuser[0];
            seen_out.status      = t_status'(m_axis_tuser[2:1]);
            seen_out.cp437_code  = m_axis_tdata[7:0];
            seen_out.char_count  = m_axis_tdata[23:8];
            seen_out.string_done = m_axis_tlast;
            if (expected_out.size() == 0) begin
                $error("unexpected transaction: tdata 0x%0h tuser 0x%0h",
                       m_axis_tdata, m_axis_tuser);
                n_fail++;
            end else begin
                want_out = expected_out.pop_front();
                check_field("char_valid", want_out.char_valid, seen_out.char_valid);
                check_field("cp437_code", want_out.cp437_code, seen_out.cp437_code);
                check_field("status", want_out.status, seen_out.status);
                check_field("char_count", want_out.char_count, seen_out.char_count);
                check_field("string_done", want_out.string_done, seen_out.string_done);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        logic [15:0] cap;
        logic        lim;
        int          phase_end;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed bytes at the reset config (capacity 65535, limit on)
        for (int r = 0; r < N_DIRECTED; r++)
            send_item(BYTE_TABLE[r].byte_val, BYTE_TABLE[r].last, BYTE_TABLE[r].data,
                      BYTE_TABLE[r].want);

        // random strings under a series of configs; the first few are the
        // corner settings, including capacity 0 with the limit on, which rejects every string
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    cap = 16'd0;
                    lim = 1'b1;
                end
                1: begin
                    cap = 16'd1;
                    lim = 1'b1;
                end
                2: begin
                    cap = 16'd3;
                    lim = 1'b1;
                end
                3: begin
                    cap = 16'd0;
                    lim = 1'b0;
                end
                4: begin
                    cap = 16'hFFFF;
                    lim = 1'b0;
                end
                default: begin
                    cap = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 8));
                    lim = 1'($urandom_range(0, 1));
                end
            endcase
            write_config(cap, lim);
            // phase 2: receiver holds off while the sender keeps pushing,
            // so the queue fills and s_axis_tready drops
            hold_req = (ph == 2);
            quiet    = (ph == 6);
            phase_end = n_sent + ITEMS_PER_PHASE;
            while (n_sent < phase_end)
                send_random_string();
        end
        quiet = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
